FILE: hw/rtl/tap_hold_swipe_gesture_mapper_assert.svh
// Assertion macros for the tap/hold/swipe gesture mapper
`ifndef TAP_HOLD_SWIPE_GESTURE_MAPPER_ASSERT_SVH
`define TAP_HOLD_SWIPE_GESTURE_MAPPER_ASSERT_SVH

`define THSG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gesture mapper check failed");

`define THSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gesture mapper check failed");

`endif

FILE: hw/rtl/thsg_pkg.sv
// Package: types, codes and helpers of the gesture mapper
`default_nettype none
package thsg_pkg;

  localparam int THSG_TIME_BITS = 32;
  localparam int QBITS = 11;
  localparam int CNT_W = 4;

  localparam logic [2:0] REG_PROFILE  = 3'd0;
  localparam logic [2:0] REG_HOLD_THR = 3'd1;
  localparam logic [2:0] REG_TAP      = 3'd2;
  localparam logic [2:0] REG_DUR      = 3'd3;
  localparam logic [2:0] REG_LAYOUT   = 3'd4;

  localparam logic [2:0] PROF_OFF          = 3'd0;
  localparam logic [2:0] PROF_VIEW_UP      = 3'd1;
  localparam logic [2:0] PROF_VIEW_LEFT_UP = 3'd2;
  localparam logic [2:0] PROF_VIEW_LEFT    = 3'd3;
  localparam logic [2:0] PROF_STICK        = 3'd4;
  localparam logic [2:0] PROF_FACE         = 3'd5;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PENDING = 2'd1;
  localparam logic [1:0] PH_PULSE   = 2'd2;
  localparam logic [1:0] PH_WAIT    = 2'd3;

  localparam logic [15:0] CENTER_X = 16'd960;
  localparam logic [15:0] CENTER_Y = 16'd540;
  localparam logic [15:0] LEFT_X   = 16'd320;
  localparam logic [15:0] RIGHT_X  = 16'd1600;
  localparam logic [15:0] TOP_Y    = 16'd200;
  localparam logic [15:0] BOTTOM_Y = 16'd850;
  localparam logic [7:0]  STICK_CENTER = 8'd128;
  localparam logic [7:0]  STICK_THR    = 8'd64;
  localparam logic [10:0] SPAN_Y = 11'd650;
  localparam logic [10:0] SPAN_X = 11'd1280;

  localparam logic [15:0] RST_THR    = 16'd250;
  localparam logic [15:0] RST_TAP    = 16'd50;
  localparam logic [15:0] RST_DUR    = 16'd120;
  localparam logic [23:0] RST_LAYOUT = 24'd5447706;

  typedef struct packed {
    logic capture;
    logic step;
    logic div_init;
    logic div_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic draw;
  } dp_sts_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       restart;
    logic       tap;
    logic       fire;
  } hold_res_t;

  function automatic logic [15:0] lbit(input logic [23:0] lay, input logic [2:0] slot);
    lbit = 16'h1 << lay[4*slot +: 4];
  endfunction

  function automatic hold_res_t hold_fn(input logic [1:0] ph, input logic pressed,
                                        input logic ge_thr, input logic lt_pulse);
    hold_res_t r;
    r = '{phase: ph, restart: 1'b0, tap: 1'b0, fire: 1'b0};
    unique case (ph)
      PH_IDLE: begin
        if (pressed) begin
          r.phase = PH_PENDING;
          r.restart = 1'b1;
        end
      end
      PH_PENDING: begin
        if (!pressed) begin
          r.phase = PH_PULSE;
          r.restart = 1'b1;
          r.tap = 1'b1;
        end else if (ge_thr) begin
          r.phase = PH_WAIT;
          r.fire = 1'b1;
        end
      end
      PH_PULSE: begin
        if (lt_pulse) begin
          r.tap = 1'b1;
        end else if (pressed) begin
          r.phase = PH_PENDING;
          r.restart = 1'b1;
        end else begin
          r.phase = PH_IDLE;
        end
      end
      default: begin
        if (!pressed) r.phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/thsg_ctrl.sv
// Controller: sequences capture, gesture step, division and output load
`default_nettype none
module thsg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire thsg_pkg::dp_sts_t sts,
  output thsg_pkg::ctl_cmd_t     cmd
);
  import thsg_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_STEP, S_INIT, S_DIV, S_FIN} state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.capture  = (state_r == S_IDLE) && in_valid;
    cmd.step     = (state_r == S_STEP);
    cmd.div_init = (state_r == S_INIT) && sts.draw;
    cmd.div_step = (state_r == S_DIV);
    cmd.load_out = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_STEP;
      S_STEP: state_nxt = S_INIT;
      S_INIT: begin
        cnt_nxt = '0;
        state_nxt = sts.draw ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QBITS - 1)) state_nxt = S_FIN;
      end
      S_FIN: if (cmd.load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    priority if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (!out_stall)       out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: hw/rtl/thsg_dp.sv
// Datapath: configuration, gesture state, swipe divider and output registers
`default_nettype none
module thsg_dp #(
  parameter int TIME_BITS = thsg_pkg::THSG_TIME_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [23:0]        cfg_wdata,
  input  wire logic [15:0]        in_buttons_in,
  input  wire logic [7:0]         in_dpad_in,
  input  wire logic [7:0]         in_stick_x_in,
  input  wire logic [7:0]         in_stick_y_in,
  input  wire logic [15:0]        in_touch_x_in,
  input  wire logic [15:0]        in_touch_y_in,
  input  wire logic               in_touch_active_in,
  input  wire logic [31:0]        in_time_ms,
  input  wire thsg_pkg::ctl_cmd_t cmd,
  output thsg_pkg::dp_sts_t       sts,
  output logic [15:0]             out_buttons_out,
  output logic [7:0]              out_dpad_out,
  output logic [7:0]              out_stick_x_out,
  output logic [7:0]              out_stick_y_out,
  output logic [15:0]             out_touch_x_out,
  output logic [15:0]             out_touch_y_out,
  output logic                    out_touch_active_out
);
  import thsg_pkg::*;

  localparam int TW = TIME_BITS;

  logic [2:0]  profile_r;
  logic [15:0] thr_r, pulse_r, dur_r;
  logic [23:0] layout_r;

  logic [15:0] bi_r, txi_r, tyi_r;
  logic [7:0]  di_r, sxi_r, syi_r;
  logic        tai_r;
  logic [TW-1:0] now_r;

  logic [1:0]    vh_phase_r, vh_phase_nxt, uh_phase_r, uh_phase_nxt;
  logic [TW-1:0] vh_start_r, vh_start_nxt, uh_start_r, uh_start_nxt;
  logic          sw_act_r, sw_act_nxt;
  logic [1:0]    sw_dir_r, sw_dir_nxt;
  logic [TW-1:0] sw_start_r, sw_start_nxt;
  logic          st_tap_r, st_tap_nxt;
  logic [TW-1:0] st_tstart_r, st_tstart_nxt;
  logic          st_prev_r, st_prev_nxt, st_armed_r, st_armed_nxt, st_fired_r, st_fired_nxt;
  logic          fc_tap_r, fc_tap_nxt;
  logic [TW-1:0] fc_tstart_r, fc_tstart_nxt;
  logic          fc_prev_r, fc_prev_nxt, fc_armed_r, fc_armed_nxt, fc_fired_r, fc_fired_nxt;
  logic          fc_pass_r, fc_pass_nxt;
  logic [15:0]   fc_mask_r, fc_mask_nxt;

  logic [15:0] b_v, tx_v, ty_v;
  logic [7:0]  d_v, sx_v, sy_v;
  logic        ta_v, draw_v;
  logic [TW-1:0] el_v;
  hold_res_t   vh, uh;
  logic [15:0] tp, r1, fbit;
  logic [1:0]  fdir;
  logic        has_face, fmod, smod, neutral;
  logic [7:0]  ax, ay;
  logic [TW-1:0] d_view, d_up, d_stap, d_ftap;
  logic [TW-1:0] thr_w, pulse_w, dur_w;

  logic [15:0] rb_r, rtx_r, rty_r;
  logic [7:0]  rd_r, rsx_r, rsy_r;
  logic        rta_r, draw_r;
  logic [15:0] el_r;

  logic [15:0] rem_r;
  logic [QBITS-1:0] lo_r, q_r;
  logic [26:0] prod;
  logic [16:0] trial;
  logic        ge;
  logic [10:0] span;

  assign thr_w   = TW'(thr_r);
  assign pulse_w = TW'(pulse_r);
  assign dur_w   = TW'(dur_r);
  assign d_view  = now_r - vh_start_r;
  assign d_up    = now_r - uh_start_r;
  assign d_stap  = now_r - st_tstart_r;
  assign d_ftap  = now_r - fc_tstart_r;
  assign tp      = lbit(layout_r, 3'd0);
  assign r1      = lbit(layout_r, 3'd5);
  assign fmod    = (bi_r & r1) != 16'd0;
  assign smod    = di_r[3];
  assign ax      = (sxi_r >= STICK_CENTER) ? sxi_r - STICK_CENTER : STICK_CENTER - sxi_r;
  assign ay      = (syi_r >= STICK_CENTER) ? syi_r - STICK_CENTER : STICK_CENTER - syi_r;
  assign neutral = (ax < STICK_THR) && (ay < STICK_THR);
  assign vh = hold_fn(vh_phase_r, (bi_r & tp) != 16'd0, d_view >= thr_w, d_view < pulse_w);
  assign uh = hold_fn(uh_phase_r, di_r[0], d_up >= thr_w, d_up < pulse_w);

  always_comb begin
    has_face = 1'b0;
    fdir = DIR_UP;
    fbit = '0;
    for (int i = 3; i >= 0; i--) begin
      if ((bi_r & lbit(layout_r, 3'(i + 1))) != 16'd0) begin
        has_face = 1'b1;
        fdir = 2'(i);
        fbit = lbit(layout_r, 3'(i + 1));
      end
    end
  end

  always_comb begin
    vh_phase_nxt = vh_phase_r; vh_start_nxt = vh_start_r;
    uh_phase_nxt = uh_phase_r; uh_start_nxt = uh_start_r;
    sw_act_nxt = sw_act_r; sw_dir_nxt = sw_dir_r; sw_start_nxt = sw_start_r;
    st_tap_nxt = st_tap_r; st_tstart_nxt = st_tstart_r;
    st_prev_nxt = st_prev_r; st_armed_nxt = st_armed_r; st_fired_nxt = st_fired_r;
    fc_tap_nxt = fc_tap_r; fc_tstart_nxt = fc_tstart_r;
    fc_prev_nxt = fc_prev_r; fc_armed_nxt = fc_armed_r; fc_fired_nxt = fc_fired_r;
    fc_pass_nxt = fc_pass_r; fc_mask_nxt = fc_mask_r;
    b_v = bi_r; d_v = di_r; sx_v = sxi_r; sy_v = syi_r;
    tx_v = txi_r; ty_v = tyi_r; ta_v = tai_r;
    draw_v = 1'b0;
    el_v = '0;
    unique case (profile_r)
      PROF_VIEW_UP, PROF_VIEW_LEFT_UP, PROF_VIEW_LEFT: begin
        b_v = b_v & ~tp;
        vh_phase_nxt = vh.phase;
        if (vh.restart) vh_start_nxt = now_r;
        if (vh.fire && !sw_act_nxt) begin
          sw_act_nxt = 1'b1;
          sw_dir_nxt = (profile_r == PROF_VIEW_UP) ? DIR_UP : DIR_LEFT;
          sw_start_nxt = now_r;
        end
        if (vh.tap) begin
          b_v = b_v | tp;
          tx_v = CENTER_X;
          ty_v = CENTER_Y;
          ta_v = 1'b1;
        end
        if (profile_r == PROF_VIEW_LEFT_UP) begin
          d_v[0] = 1'b0;
          uh_phase_nxt = uh.phase;
          if (uh.restart) uh_start_nxt = now_r;
          if (uh.fire && !sw_act_nxt) begin
            sw_act_nxt = 1'b1;
            sw_dir_nxt = DIR_UP;
            sw_start_nxt = now_r;
          end
          if (uh.tap) d_v[0] = 1'b1;
        end
      end
      PROF_STICK: begin
        if (st_tap_r) begin
          if (d_stap < pulse_w) d_v[3] = 1'b1;
          else st_tap_nxt = 1'b0;
        end
        if (smod) begin
          d_v[3] = 1'b0;
          if (!st_prev_r) begin
            st_armed_nxt = neutral;
            st_fired_nxt = 1'b0;
            st_tap_nxt = 1'b0;
          end
          if (st_armed_nxt && !st_fired_nxt && !neutral) begin
            if (!sw_act_nxt) begin
              sw_act_nxt = 1'b1;
              if (ax > ay) sw_dir_nxt = (sxi_r < STICK_CENTER) ? DIR_LEFT : DIR_RIGHT;
              else sw_dir_nxt = (syi_r < STICK_CENTER) ? DIR_UP : DIR_DOWN;
              sw_start_nxt = now_r;
            end
            st_fired_nxt = 1'b1;
          end
          if (st_fired_nxt) begin
            sx_v = STICK_CENTER;
            sy_v = STICK_CENTER;
          end
        end else if (st_prev_r) begin
          if (!st_fired_r) begin
            st_tap_nxt = 1'b1;
            st_tstart_nxt = now_r;
            d_v[3] = 1'b1;
          end
          st_armed_nxt = 1'b0;
          st_fired_nxt = 1'b0;
        end
        st_prev_nxt = smod;
      end
      PROF_FACE: begin
        if (fc_tap_r) begin
          if (d_ftap < pulse_w) b_v = b_v | r1;
          else fc_tap_nxt = 1'b0;
        end
        if (fmod && !fc_prev_r && has_face) begin
          fc_pass_nxt = 1'b1;
          fc_armed_nxt = 1'b0;
          fc_fired_nxt = 1'b0;
          fc_tap_nxt = 1'b0;
        end
        if (fc_pass_nxt) begin
          if (!fmod) fc_pass_nxt = 1'b0;
        end else if (fmod) begin
          b_v = b_v & ~r1;
          if (!fc_prev_r) begin
            fc_armed_nxt = !has_face;
            fc_fired_nxt = 1'b0;
            fc_mask_nxt = '0;
            fc_tap_nxt = 1'b0;
          end
          if (fc_armed_nxt && !fc_fired_nxt && fc_prev_r && has_face) begin
            if (!sw_act_nxt) begin
              sw_act_nxt = 1'b1;
              sw_dir_nxt = fdir;
              sw_start_nxt = now_r;
            end
            fc_fired_nxt = 1'b1;
            fc_mask_nxt = fbit;
          end
          if (fc_fired_nxt) b_v = b_v & ~fc_mask_nxt;
        end else if (fc_prev_r) begin
          if (!fc_fired_r) begin
            fc_tap_nxt = 1'b1;
            fc_tstart_nxt = now_r;
            b_v = b_v | r1;
          end
          fc_armed_nxt = 1'b0;
          fc_fired_nxt = 1'b0;
          fc_mask_nxt = '0;
        end
        fc_prev_nxt = fmod;
      end
      default: ;
    endcase
    if ((profile_r >= PROF_VIEW_UP) && (profile_r <= PROF_FACE) && sw_act_nxt) begin
      el_v = now_r - sw_start_nxt;
      if (el_v >= dur_w) begin
        sw_act_nxt = 1'b0;
      end else begin
        draw_v = 1'b1;
        b_v = b_v & ~tp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profile_r <= PROF_OFF;
      thr_r <= RST_THR;
      pulse_r <= RST_TAP;
      dur_r <= RST_DUR;
      layout_r <= RST_LAYOUT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PROFILE:  profile_r <= cfg_wdata[2:0];
        REG_HOLD_THR: thr_r <= cfg_wdata[15:0];
        REG_TAP:      pulse_r <= cfg_wdata[15:0];
        REG_DUR:      dur_r <= cfg_wdata[15:0];
        REG_LAYOUT:   layout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_phase_r <= PH_IDLE; vh_start_r <= '0;
      uh_phase_r <= PH_IDLE; uh_start_r <= '0;
      sw_act_r <= 1'b0; sw_dir_r <= DIR_UP; sw_start_r <= '0;
      st_tap_r <= 1'b0; st_tstart_r <= '0;
      st_prev_r <= 1'b0; st_armed_r <= 1'b0; st_fired_r <= 1'b0;
      fc_tap_r <= 1'b0; fc_tstart_r <= '0;
      fc_prev_r <= 1'b0; fc_armed_r <= 1'b0; fc_fired_r <= 1'b0;
      fc_pass_r <= 1'b0; fc_mask_r <= '0;
      draw_r <= 1'b0;
    end else if (cmd.step) begin
      vh_phase_r <= vh_phase_nxt; vh_start_r <= vh_start_nxt;
      uh_phase_r <= uh_phase_nxt; uh_start_r <= uh_start_nxt;
      sw_act_r <= sw_act_nxt; sw_dir_r <= sw_dir_nxt; sw_start_r <= sw_start_nxt;
      st_tap_r <= st_tap_nxt; st_tstart_r <= st_tstart_nxt;
      st_prev_r <= st_prev_nxt; st_armed_r <= st_armed_nxt; st_fired_r <= st_fired_nxt;
      fc_tap_r <= fc_tap_nxt; fc_tstart_r <= fc_tstart_nxt;
      fc_prev_r <= fc_prev_nxt; fc_armed_r <= fc_armed_nxt; fc_fired_r <= fc_fired_nxt;
      fc_pass_r <= fc_pass_nxt; fc_mask_r <= fc_mask_nxt;
      draw_r <= draw_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bi_r <= in_buttons_in; di_r <= in_dpad_in;
      sxi_r <= in_stick_x_in; syi_r <= in_stick_y_in;
      txi_r <= in_touch_x_in; tyi_r <= in_touch_y_in;
      tai_r <= in_touch_active_in;
      now_r <= TW'(in_time_ms);
    end
    if (cmd.step) begin
      rb_r <= b_v; rd_r <= d_v; rsx_r <= sx_v; rsy_r <= sy_v;
      rtx_r <= tx_v; rty_r <= ty_v; rta_r <= ta_v;
      el_r <= el_v[15:0];
    end
  end

  assign span  = (sw_dir_r == DIR_UP || sw_dir_r == DIR_DOWN) ? SPAN_Y : SPAN_X;
  assign prod  = 27'(span) * 27'(el_r);
  assign trial = {rem_r, lo_r[QBITS-1]};
  assign ge    = trial >= {1'b0, dur_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= prod[26:QBITS];
      lo_r <= prod[QBITS-1:0];
      q_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? 16'(trial - {1'b0, dur_r}) : trial[15:0];
      lo_r <= {lo_r[QBITS-2:0], 1'b0};
      q_r <= {q_r[QBITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_buttons_out <= rb_r;
      out_dpad_out <= rd_r;
      out_stick_x_out <= rsx_r;
      out_stick_y_out <= rsy_r;
      if (draw_r) begin
        out_touch_active_out <= 1'b1;
        unique case (sw_dir_r)
          DIR_UP: begin
            out_touch_x_out <= CENTER_X;
            out_touch_y_out <= BOTTOM_Y - 16'(q_r);
          end
          DIR_DOWN: begin
            out_touch_x_out <= CENTER_X;
            out_touch_y_out <= TOP_Y + 16'(q_r);
          end
          DIR_LEFT: begin
            out_touch_x_out <= RIGHT_X - 16'(q_r);
            out_touch_y_out <= CENTER_Y;
          end
          default: begin
            out_touch_x_out <= LEFT_X + 16'(q_r);
            out_touch_y_out <= CENTER_Y;
          end
        endcase
      end else begin
        out_touch_x_out <= rtx_r;
        out_touch_y_out <= rty_r;
        out_touch_active_out <= rta_r;
      end
    end
  end

  assign sts.draw = draw_r;

endmodule
`default_nettype wire

FILE: hw/rtl/tap_hold_swipe_gesture_mapper.sv
// Tap/hold/swipe gesture mapper for controller reports.
// Input channel in_*: one report per transaction (buttons, d-pad, right stick,
//   first touch point, millisecond timestamp), taken when in_valid is high
//   and in_stall is low.
// Output channel out_*: exactly one rewritten report per input transaction,
//   in order, held in an output register while out_stall is high.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (0 profile,
//   1 hold threshold, 2 tap pulse, 3 swipe duration, 4 button layout);
//   write only while no report is in flight.
// Sequence: an accepted report is captured, run through the gesture step
//   and the divider set-up, and loaded into the output register; only when a
//   swipe point is interpolated does the divider run between set-up and load,
//   resolving one quotient bit per cycle, 11 bits in all. A new report is
//   accepted as soon as the previous one has moved into the output register.
// Reset (rst_n low, synchronous): registers return to their defaults, all
//   gesture state clears and out_valid drops.
// A stalled receiver holds the result; the next report is still accepted
//   and waits in the final stage until the output register frees.
`default_nettype none
module tap_hold_swipe_gesture_mapper #(
  parameter int TIME_BITS = thsg_pkg::THSG_TIME_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_buttons_in,
  input  wire logic [7:0]  in_dpad_in,
  input  wire logic [7:0]  in_stick_x_in,
  input  wire logic [7:0]  in_stick_y_in,
  input  wire logic [15:0] in_touch_x_in,
  input  wire logic [15:0] in_touch_y_in,
  input  wire logic        in_touch_active_in,
  input  wire logic [31:0] in_time_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_buttons_out,
  output logic [7:0]       out_dpad_out,
  output logic [7:0]       out_stick_x_out,
  output logic [7:0]       out_stick_y_out,
  output logic [15:0]      out_touch_x_out,
  output logic [15:0]      out_touch_y_out,
  output logic             out_touch_active_out
);
  import thsg_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  thsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  thsg_dp #(.TIME_BITS(TIME_BITS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata),
    .in_buttons_in        (in_buttons_in),
    .in_dpad_in           (in_dpad_in),
    .in_stick_x_in        (in_stick_x_in),
    .in_stick_y_in        (in_stick_y_in),
    .in_touch_x_in        (in_touch_x_in),
    .in_touch_y_in        (in_touch_y_in),
    .in_touch_active_in   (in_touch_active_in),
    .in_time_ms           (in_time_ms),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_buttons_out      (out_buttons_out),
    .out_dpad_out         (out_dpad_out),
    .out_stick_x_out      (out_stick_x_out),
    .out_stick_y_out      (out_stick_y_out),
    .out_touch_x_out      (out_touch_x_out),
    .out_touch_y_out      (out_touch_y_out),
    .out_touch_active_out (out_touch_active_out)
  );

`include "tap_hold_swipe_gesture_mapper_assert.svh"

  `THSG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `THSG_ASSERT_SAME(a_cmd_exclusive, 1'b1,
    $onehot0({cmd.capture, cmd.step, cmd.div_init, cmd.div_step, cmd.load_out}))
  `THSG_ASSERT_SAME(a_no_overwrite, cmd.load_out, !(out_valid && out_stall))
  `THSG_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid)

endmodule
`default_nettype wire
